// File: src/gnss_binary_frame_deframer_top_defines.svh
// ----------------------------------------------------------------------------
// gnss binary frame deframer assertion macros
// shared concurrent assertion forms for the deframer top level
// ----------------------------------------------------------------------------
`ifndef GNSS_BINARY_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define GNSS_BINARY_FRAME_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GBFD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define GBFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/gbfd_pkg.sv
// ----------------------------------------------------------------------------
// gbfd_pkg
// types, constants and crc helper for the binary frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package gbfd_pkg;

   localparam int BYTE_W   = 8;
   localparam int IDX_W    = 14;
   localparam int STATUS_W = 3;
   localparam int TYPE_W   = 16;
   localparam int WEEK_W   = 16;
   localparam int TOW_W    = 32;
   localparam int CRC_W    = 32;

   localparam logic [BYTE_W-1:0] SYNC_A = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_B = 8'h44;
   localparam logic [BYTE_W-1:0] SYNC_C = 8'hB5;

   localparam int HDR_BYTES = 24;
   localparam int CRC_BYTES = 4;

   // header byte positions, counted from the first sync byte
   localparam int POS_TYPE_LO  = 4;
   localparam int POS_TYPE_HI  = 5;
   localparam int POS_LEN_LO   = 6;
   localparam int POS_LEN_HI   = 7;
   localparam int POS_HDR_CRC  = 8;
   localparam int POS_TSTAT    = 9;
   localparam int POS_WEEK_LO  = 10;
   localparam int POS_WEEK_HI  = 11;
   localparam int POS_TOW_B0   = 12;
   localparam int POS_TOW_B1   = 13;
   localparam int POS_TOW_B2   = 14;
   localparam int POS_TOW_B3   = 15;
   localparam int POS_AFTER_SYNC = 3;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

   localparam logic [BYTE_W-1:0] TIME_STATUS_INVALID = 8'd201;

   localparam logic [TYPE_W-1:0] MSG_B2B_0 = 16'd2302;
   localparam logic [TYPE_W-1:0] MSG_B2B_1 = 16'd2304;
   localparam logic [TYPE_W-1:0] MSG_B2B_2 = 16'd2306;
   localparam logic [TYPE_W-1:0] MSG_B2B_3 = 16'd2308;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_B2B_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OTHER_TYPE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TIME   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_CRC_ERROR  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_LEN_ERROR  = 3'd4;

   typedef struct packed {
      logic                item_kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [IDX_W-1:0]    payload_index;
      logic [STATUS_W-1:0] frame_status;
      logic [TYPE_W-1:0]   message_type;
      logic [WEEK_W-1:0]   gps_week;
      logic [TOW_W-1:0]    week_time_ms;
      logic [IDX_W-1:0]    payload_length;
   } gbfd_result_type;

   // reflected crc-32, one byte, lsb first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // crc after the three sync bytes
   localparam logic [CRC_W-1:0] CRC_AFTER_SYNC =
      crc_byte(crc_byte(crc_byte('0, SYNC_A), SYNC_B), SYNC_C);

endpackage

`default_nettype wire

// File: src/gbfd_if.sv
// ----------------------------------------------------------------------------
// gbfd channel interfaces
// valid/ready channels for received bytes and deframer results
// ----------------------------------------------------------------------------
`default_nettype none

interface gbfd_req_if;
   import gbfd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gbfd_rsp_if;
   import gbfd_pkg::*;

   logic                valid;
   logic                ready;
   logic                item_kind;
   logic [BYTE_W-1:0]   payload_byte;
   logic [IDX_W-1:0]    payload_index;
   logic [STATUS_W-1:0] frame_status;
   logic [TYPE_W-1:0]   message_type;
   logic [WEEK_W-1:0]   gps_week;
   logic [TOW_W-1:0]    week_time_ms;
   logic [IDX_W-1:0]    payload_length;

   modport source (output valid, output item_kind, output payload_byte,
                   output payload_index, output frame_status, output message_type,
                   output gps_week, output week_time_ms, output payload_length,
                   input ready);
   modport sink   (input valid, input item_kind, input payload_byte,
                   input payload_index, input frame_status, input message_type,
                   input gps_week, input week_time_ms, input payload_length,
                   output ready);
endinterface

`default_nettype wire

// File: src/gbfd_parser.sv
// ----------------------------------------------------------------------------
// gbfd_parser
// sync hunt, header capture, crc update and result forming, one byte a cycle while byte_accept is high
// ----------------------------------------------------------------------------
`default_nettype none

module gbfd_parser #(
   parameter int MAX_FRAME_BYTES = 16384
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      byte_accept,
   input  wire logic [gbfd_pkg::BYTE_W-1:0] rx_byte,
   output logic                           result_valid,
   output gbfd_pkg::gbfd_result_type      result
);
   import gbfd_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LEN_W = 2 * BYTE_W + 1;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_FRAME_BYTES - CRC_BYTES);

   logic [BYTE_W-1:0] win1_ff, win1_in, win2_ff, win2_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  flen_ff, flen_in;
   logic [BYTE_W-1:0] len_lo_ff, len_lo_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [CRC_W-1:0]  rcrc_ff, rcrc_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [BYTE_W-1:0] tstat_ff, tstat_in;
   logic [WEEK_W-1:0] week_ff, week_in;
   logic [TOW_W-1:0]  tow_ff, tow_in;

   logic [LEN_W-1:0]  full_len;
   logic [CNT_W-1:0]  rel_pos;
   logic [CNT_W-1:0]  plen;
   logic              len_bad;
   logic              frame_done;

   assign full_len   = {1'b0, rx_byte, len_lo_ff} + LEN_W'(HDR_BYTES);
   assign len_bad    = full_len > LEN_LIMIT;
   assign rel_pos    = cnt_ff - CNT_W'(HDR_BYTES);
   assign plen       = flen_ff - CNT_W'(HDR_BYTES);
   assign frame_done = ({1'b0, cnt_ff} + (CNT_W+1)'(1)) >=
                       ({1'b0, flen_ff} + (CNT_W+1)'(CRC_BYTES));

   always_comb begin
      win1_in      = win1_ff;
      win2_in      = win2_ff;
      cnt_in       = cnt_ff;
      flen_in      = flen_ff;
      len_lo_in    = len_lo_ff;
      crc_in       = crc_ff;
      rcrc_in      = rcrc_ff;
      type_in      = type_ff;
      tstat_in     = tstat_ff;
      week_in      = week_ff;
      tow_in       = tow_ff;
      result_valid = 1'b0;
      result       = '0;

      if (cnt_ff == '0) begin
         // hunting: shift window, look for the sync pattern
         win1_in = win2_ff;
         win2_in = rx_byte;
         if (win1_ff == SYNC_A && win2_ff == SYNC_B && rx_byte == SYNC_C) begin
            cnt_in  = CNT_W'(POS_AFTER_SYNC);
            crc_in  = CRC_AFTER_SYNC;
            rcrc_in = '0;
            flen_in = '0;
         end
      end else begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff < CNT_W'(POS_HDR_CRC) || cnt_ff < flen_ff) begin
            crc_in = crc_byte(crc_ff, rx_byte);
         end

         case (cnt_ff)
            CNT_W'(POS_TYPE_LO): type_in  = {{(TYPE_W-BYTE_W){1'b0}}, rx_byte};
            CNT_W'(POS_TYPE_HI): type_in  = {rx_byte, type_ff[BYTE_W-1:0]};
            CNT_W'(POS_LEN_LO):  len_lo_in = rx_byte;
            CNT_W'(POS_TSTAT):   tstat_in = rx_byte;
            CNT_W'(POS_WEEK_LO): week_in  = {{(WEEK_W-BYTE_W){1'b0}}, rx_byte};
            CNT_W'(POS_WEEK_HI): week_in  = {rx_byte, week_ff[BYTE_W-1:0]};
            CNT_W'(POS_TOW_B0):  tow_in   = {{(TOW_W-BYTE_W){1'b0}}, rx_byte};
            CNT_W'(POS_TOW_B1):  tow_in   = {tow_ff[31:16], rx_byte, tow_ff[7:0]};
            CNT_W'(POS_TOW_B2):  tow_in   = {tow_ff[31:24], rx_byte, tow_ff[15:0]};
            CNT_W'(POS_TOW_B3):  tow_in   = {rx_byte, tow_ff[23:0]};
            default: ;
         endcase

         if (cnt_ff == CNT_W'(POS_LEN_HI)) begin
            if (len_bad) begin
               // frame cannot fit: report and go back to hunting
               cnt_in                = '0;
               flen_in               = '0;
               result_valid          = 1'b1;
               result.item_kind      = KIND_VERDICT;
               result.frame_status   = STATUS_LEN_ERROR;
               result.message_type   = type_ff;
            end else begin
               flen_in = full_len[CNT_W-1:0];
            end
         end else if (cnt_ff >= CNT_W'(POS_HDR_CRC)) begin
            if (cnt_ff < flen_ff) begin
               if (cnt_ff >= CNT_W'(HDR_BYTES)) begin
                  result_valid          = 1'b1;
                  result.item_kind      = KIND_PAYLOAD;
                  result.payload_byte   = rx_byte;
                  result.payload_index  = IDX_W'(rel_pos);
                  result.frame_status   = STATUS_B2B_OK;
                  result.message_type   = type_ff;
                  result.gps_week       = week_ff;
                  result.week_time_ms   = tow_ff;
                  result.payload_length = IDX_W'(plen);
               end
            end else begin
               // trailing crc bytes, little endian
               rcrc_in = {rx_byte, rcrc_ff[CRC_W-1:BYTE_W]};
               if (frame_done) begin
                  cnt_in                = '0;
                  result_valid          = 1'b1;
                  result.item_kind      = KIND_VERDICT;
                  result.message_type   = type_ff;
                  result.gps_week       = week_ff;
                  result.week_time_ms   = tow_ff;
                  result.payload_length = IDX_W'(plen);
                  if (crc_ff != rcrc_in) begin
                     result.frame_status = STATUS_CRC_ERROR;
                  end else if (tstat_ff == TIME_STATUS_INVALID || week_ff == '0) begin
                     result.frame_status = STATUS_BAD_TIME;
                  end else if (type_ff inside {MSG_B2B_0, MSG_B2B_1,
                                               MSG_B2B_2, MSG_B2B_3}) begin
                     result.frame_status = STATUS_B2B_OK;
                  end else begin
                     result.frame_status = STATUS_OTHER_TYPE;
                  end
               end
            end
         end
      end

      if (!byte_accept) begin
         result_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win1_ff <= '0;
         win2_ff <= '0;
         cnt_ff  <= '0;
         flen_ff <= '0;
      end else if (byte_accept) begin
         win1_ff <= win1_in;
         win2_ff <= win2_in;
         cnt_ff  <= cnt_in;
         flen_ff <= flen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_accept) begin
         len_lo_ff <= len_lo_in;
         crc_ff    <= crc_in;
         rcrc_ff   <= rcrc_in;
         type_ff   <= type_in;
         tstat_ff  <= tstat_in;
         week_ff   <= week_in;
         tow_ff    <= tow_in;
      end
   end

endmodule

`default_nettype wire

// File: src/gbfd_out_buf.sv
// ----------------------------------------------------------------------------
// gbfd_out_buf
// result register with a skid stage so the byte side keeps flowing
// ----------------------------------------------------------------------------
`default_nettype none

module gbfd_out_buf (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire gbfd_pkg::gbfd_result_type push_data,
   output logic                           space,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output gbfd_pkg::gbfd_result_type      out_data
);
   import gbfd_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   gbfd_result_type main_ff, main_in;
   gbfd_result_type skid_ff, skid_in;
   logic            pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// File: src/gnss_binary_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// gnss_binary_frame_deframer_top
// byte-serial deframer for sync AA 44 B5 binary frames with crc-32 check
// ----------------------------------------------------------------------------
// usage
//   req_if carries one received byte per transfer (rx_byte)
//   rsp_if carries payload byte items and one verdict item per frame
//   a byte is taken in every cycle while req_if.ready is high; the sync hunt,
//   header capture and byte-wide crc update all finish in the cycle of the
//   transfer, so the rate is one byte per clock
//   a payload or verdict item passes through the output register, or the skid
//   stage when stalled, to rsp_if; other sync, header and crc bytes give no item
//   a length whose frame overruns MAX_FRAME_BYTES gives a length-error
//   verdict right after header byte 7 and the hunt restarts
//   when the receiver stalls, one result sits in the output register and a
//   second one in the skid stage; only with both full does req_if.ready drop
//   synchronous reset returns to hunting with an empty sync window and drops
//   any result still held; no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

`include "gnss_binary_frame_deframer_top_defines.svh"

module gnss_binary_frame_deframer_top #(
   parameter int MAX_FRAME_BYTES = 16384
) (
   input wire logic   clock,
   input wire logic   reset,
   gbfd_req_if.sink   req_if,
   gbfd_rsp_if.source rsp_if
);
   import gbfd_pkg::*;

   // byte transfer and the result it produces
   logic            byte_accept;
   logic            result_valid;
   gbfd_result_type result;

   // output side
   logic            buf_space;
   gbfd_result_type out_data;

   assign req_if.ready = buf_space;
   assign byte_accept  = req_if.valid && buf_space;

   // framing state machine and crc, one byte per transfer
   gbfd_parser #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_if.rx_byte),
      .result_valid(result_valid),
      .result      (result)
   );

   // result register plus skid stage
   gbfd_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (result_valid),
      .push_data(result),
      .space    (buf_space),
      .out_valid(rsp_if.valid),
      .out_ready(rsp_if.ready),
      .out_data (out_data)
   );

   assign rsp_if.item_kind      = out_data.item_kind;
   assign rsp_if.payload_byte   = out_data.payload_byte;
   assign rsp_if.payload_index  = out_data.payload_index;
   assign rsp_if.frame_status   = out_data.frame_status;
   assign rsp_if.message_type   = out_data.message_type;
   assign rsp_if.gps_week       = out_data.gps_week;
   assign rsp_if.week_time_ms   = out_data.week_time_ms;
   assign rsp_if.payload_length = out_data.payload_length;

   // a blocked input side means both result slots are full
   `GBFD_ASSERT_IMPLIES(a_stall_has_result, clock, reset, !req_if.ready, rsp_if.valid, "input stalled with no result pending")

   // backpressure only after a stalled result plus a new one
   `GBFD_ASSERT_NEXT(a_full_after_stall, clock, reset, rsp_if.valid && !rsp_if.ready && result_valid && req_if.ready, !req_if.ready, "skid stage not filled")

   // length error verdicts carry no time or length
   `GBFD_ASSERT_IMPLIES(a_len_err_fields, clock, reset, rsp_if.valid && rsp_if.item_kind == KIND_VERDICT && rsp_if.frame_status == STATUS_LEN_ERROR, rsp_if.gps_week == '0 && rsp_if.week_time_ms == '0 && rsp_if.payload_length == '0, "length error verdict with header data")

   // payload items never carry a verdict code
   `GBFD_ASSERT_IMPLIES(a_payload_status, clock, reset, rsp_if.valid && rsp_if.item_kind == KIND_PAYLOAD, rsp_if.frame_status == STATUS_B2B_OK && rsp_if.payload_index < rsp_if.payload_length, "payload item fields out of range")

endmodule

`default_nettype wire

// File: verif/gnss_binary_frame_deframer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_binary_frame_deframer_top_tb
// self-checking bench: byte streams of sync words, frames and noise go in,
// an in-bench deframer model predicts payload and verdict items, a monitor
// compares every result transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------

module gnss_binary_frame_deframer_top_tb;
   import gbfd_pkg::*;

   localparam int FRAME_LIMIT     = 16384;   // MAX_FRAME_BYTES of the dut
   localparam int MAX_PAYLOAD     = FRAME_LIMIT - HDR_BYTES - CRC_BYTES;
   localparam int HOLD_OFF_CYCLES = 300;     // long receiver stall
   localparam int DRAIN_LIMIT     = 20000;
   localparam int RANDOM_BYTES    = 250;
   localparam int STREAM_BYTES    = 150;

   typedef logic [BYTE_W-1:0] octet_q_type[$];

   logic clock = 1'b0;
   logic reset;

   gbfd_req_if req_chan ();
   gbfd_rsp_if rsp_chan ();

   gnss_binary_frame_deframer_top #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_chan),
      .rsp_if(rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // global run controls shared by the sender, the receiver and the tests
   bit idling_on        = 1'b1;
   bit hold_off_request = 1'b0;
   int error_count      = 0;
   int frame_bytes_sent = 0;

   gbfd_result_type expected_results[$];

   logic [TYPE_W-1:0] b2b_types [4] = '{MSG_B2B_0, MSG_B2B_1, MSG_B2B_2, MSG_B2B_3};

   // ---------------------------------------------------------------------------
   // deframer model state, zero after reset (hunting, empty window)
   // ---------------------------------------------------------------------------
   logic [BYTE_W-1:0]   window_bytes [3] = '{default: '0};
   logic [14:0]         frame_pos  = '0;   // bytes of current frame incl. sync, 0 = hunting
   logic [14:0]         frame_end  = '0;   // header plus payload bytes
   logic [CRC_W-1:0]    crc_accum  = '0;
   logic [CRC_W-1:0]    crc_received = '0;
   logic [TYPE_W-1:0]   hdr_type   = '0;
   logic [BYTE_W-1:0]   hdr_tstat  = '0;
   logic [WEEK_W-1:0]   hdr_week   = '0;
   logic [TOW_W-1:0]    hdr_tow    = '0;

   // reflected crc-32, fed one data bit per shift
   function automatic logic [CRC_W-1:0] crc32_step(input logic [CRC_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] r;
      r = acc;
      for (int i = 0; i < BYTE_W; i++) begin
         r = (r >> 1) ^ ((r[0] ^ data[i]) ? CRC_POLY : '0);
      end
      return r;
   endfunction

   // advance the model by one accepted byte and queue the item it causes
   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      logic [14:0]     pos;
      logic [16:0]     total;
      gbfd_result_type r;
      r = '0;

      // hunting: the window only moves while no frame is open
      if (frame_pos == 0) begin
         window_bytes[0] = window_bytes[1];
         window_bytes[1] = window_bytes[2];
         window_bytes[2] = b;
         if (window_bytes[0] == SYNC_A && window_bytes[1] == SYNC_B &&
             window_bytes[2] == SYNC_C) begin
            frame_pos    = 15'(POS_AFTER_SYNC);
            crc_accum    = crc32_step(crc32_step(crc32_step('0, SYNC_A), SYNC_B), SYNC_C);
            crc_received = '0;
            frame_end    = '0;
         end
         return;
      end

      pos       = frame_pos;
      frame_pos = pos + 15'd1;
      if (pos < POS_HDR_CRC || pos < frame_end) begin
         crc_accum = crc32_step(crc_accum, b);
      end

      case (pos)
         POS_TYPE_LO: hdr_type = {8'h00, b};
         POS_TYPE_HI: hdr_type[15:8] = b;
         POS_LEN_LO:  frame_end = {7'h00, b};
         POS_LEN_HI: begin
            // oversize frame: verdict right away and back to hunting
            total = {1'b0, b, frame_end[7:0]} + 17'(HDR_BYTES);
            if (total > 17'(FRAME_LIMIT - CRC_BYTES)) begin
               frame_pos      = '0;
               frame_end      = '0;
               r.item_kind    = KIND_VERDICT;
               r.frame_status = STATUS_LEN_ERROR;
               r.message_type = hdr_type;
               expected_results.push_back(r);
            end else begin
               frame_end = total[14:0];
            end
            return;
         end
         POS_TSTAT:   hdr_tstat = b;
         POS_WEEK_LO: hdr_week = {8'h00, b};
         POS_WEEK_HI: hdr_week[15:8] = b;
         POS_TOW_B0:  hdr_tow = {24'h0, b};
         POS_TOW_B1:  hdr_tow[15:8] = b;
         POS_TOW_B2:  hdr_tow[23:16] = b;
         POS_TOW_B3:  hdr_tow[31:24] = b;
         default: ;
      endcase

      if (pos < POS_HDR_CRC) return;

      r.message_type   = hdr_type;
      r.gps_week       = hdr_week;
      r.week_time_ms   = hdr_tow;
      r.payload_length = 14'(frame_end - HDR_BYTES);

      if (pos < frame_end) begin
         if (pos >= HDR_BYTES) begin
            r.item_kind     = KIND_PAYLOAD;
            r.payload_byte  = b;
            r.payload_index = 14'(pos - HDR_BYTES);
            expected_results.push_back(r);
         end
         return;
      end

      // trailing crc, little endian
      crc_received = {b, crc_received[31:8]};
      if (frame_pos < frame_end + 15'(CRC_BYTES)) return;

      frame_pos   = '0;
      r.item_kind = KIND_VERDICT;
      // crc first, then time validity, then the message type
      if (crc_accum != crc_received) begin
         r.frame_status = STATUS_CRC_ERROR;
      end else if (hdr_tstat == TIME_STATUS_INVALID || hdr_week == 0) begin
         r.frame_status = STATUS_BAD_TIME;
      end else if (hdr_type inside {MSG_B2B_0, MSG_B2B_1, MSG_B2B_2, MSG_B2B_3}) begin
         r.frame_status = STATUS_B2B_OK;
      end else begin
         r.frame_status = STATUS_OTHER_TYPE;
      end
      expected_results.push_back(r);
   endfunction

   // ---------------------------------------------------------------------------
   // result monitor: every rsp transfer pops the oldest prediction
   // ---------------------------------------------------------------------------
   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : result_monitor
      gbfd_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected (kind %0d status %0d)",
                   rsp_chan.item_kind, rsp_chan.frame_status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("item_kind",      want.item_kind,      rsp_chan.item_kind);
            check_field("payload_byte",   want.payload_byte,   rsp_chan.payload_byte);
            check_field("payload_index",  want.payload_index,  rsp_chan.payload_index);
            check_field("frame_status",   want.frame_status,   rsp_chan.frame_status);
            check_field("message_type",   want.message_type,   rsp_chan.message_type);
            check_field("gps_week",       want.gps_week,       rsp_chan.gps_week);
            check_field("week_time_ms",   want.week_time_ms,   rsp_chan.week_time_ms);
            check_field("payload_length", want.payload_length, rsp_chan.payload_length);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: random stall bursts, plus one long hold-off counted here
   // ---------------------------------------------------------------------------
   initial begin : rsp_ready_driver
      int stall_cycles;
      bit long_hold;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         long_hold = hold_off_request;
         if (long_hold) begin
            stall_cycles = HOLD_OFF_CYCLES;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_cycles = $urandom_range(1, 10);
         end else begin
            stall_cycles = 0;
         end
         if (stall_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall_cycles) @(posedge clock);
            if (long_hold) hold_off_request = 1'b0;
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------

   // one byte transfer; valid stays high afterwards so back-to-back bytes
   // never see a low/high pair in the same step
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      deframe_byte(b);
   endtask

   function automatic octet_q_type random_payload(input int len);
      octet_q_type q;
      repeat (len) q.push_back(8'($urandom));
      return q;
   endfunction

   // full frame with correct (or one-bit corrupted) crc; keep_bytes > 0 cuts
   // the frame short after that many bytes
   task automatic send_frame(input logic [TYPE_W-1:0] msg_type, input logic [BYTE_W-1:0] tstat,
                             input logic [WEEK_W-1:0] week, input logic [TOW_W-1:0] tow,
                             input octet_q_type payload, input bit corrupt_crc,
                             input int keep_bytes);
      octet_q_type      frame;
      logic [BYTE_W-1:0] head [16];
      logic [15:0]      plen;
      logic [CRC_W-1:0] crc;
      int               n;
      plen = 16'(payload.size());
      head = '{SYNC_A, SYNC_B, SYNC_C, 8'($urandom), msg_type[7:0], msg_type[15:8],
               plen[7:0], plen[15:8], 8'($urandom), tstat, week[7:0], week[15:8],
               tow[7:0], tow[15:8], tow[23:16], tow[31:24]};
      foreach (head[i]) frame.push_back(head[i]);
      repeat (HDR_BYTES - 16) frame.push_back(8'($urandom));
      foreach (payload[i]) frame.push_back(payload[i]);
      crc = '0;
      foreach (frame[i]) crc = crc32_step(crc, frame[i]);
      if (corrupt_crc) crc ^= 32'h1 << $urandom_range(0, 31);
      for (int i = 0; i < CRC_BYTES; i++) frame.push_back(crc[8*i +: 8]);
      n = (keep_bytes > 0 && keep_bytes < frame.size()) ? keep_bytes : frame.size();
      for (int i = 0; i < n; i++) send_byte(frame[i]);
      frame_bytes_sent += n;
   endtask

   // sync plus header up to the length field, length too big for the buffer
   task automatic send_oversize_header(input logic [TYPE_W-1:0] msg_type,
                                       input logic [15:0] len_field);
      logic [BYTE_W-1:0] head [8];
      head = '{SYNC_A, SYNC_B, SYNC_C, 8'($urandom), msg_type[7:0], msg_type[15:8],
               len_field[7:0], len_field[15:8]};
      foreach (head[i]) send_byte(head[i]);
      frame_bytes_sent += 8;
   endtask

   // well-formed frame with random content, biased toward the corner values
   task automatic send_random_frame(input int keep_bytes);
      logic [TYPE_W-1:0] msg_type;
      logic [BYTE_W-1:0] tstat;
      logic [WEEK_W-1:0] week;
      logic [TOW_W-1:0]  tow;
      int                len;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: msg_type = b2b_types[$urandom_range(0, 3)];
         4:          msg_type = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         5:          msg_type = b2b_types[$urandom_range(0, 3)] + 16'd1;
         default:    msg_type = 16'($urandom);
      endcase
      tstat = ($urandom_range(0, 9) == 0) ? TIME_STATUS_INVALID : 8'($urandom);
      case ($urandom_range(0, 9))
         0:       week = 16'h0000;
         1:       week = 16'hFFFF;
         default: week = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       tow = 32'h0;
         1:       tow = 32'hFFFF_FFFF;
         default: tow = $urandom;
      endcase
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 300) : $urandom_range(0, 32);
      send_frame(msg_type, tstat, week, tow, random_payload(len),
                 $urandom_range(0, 7) == 0, keep_bytes);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // near-miss sync patterns, then a sync preceded by an extra AA, with the
   // sync word repeated inside the payload (window must stay frozen)
   task automatic test_sync_hunt();
      logic [BYTE_W-1:0] noise [11];
      octet_q_type       payload;
      noise = '{8'h00, 8'hFF, SYNC_A, SYNC_B, 8'h00, SYNC_A, 8'h55, SYNC_B, SYNC_C,
                SYNC_B, SYNC_A};
      foreach (noise[i]) send_byte(noise[i]);
      send_byte(SYNC_A);
      payload = '{SYNC_A, SYNC_B, SYNC_C, 8'h00, 8'hFF};
      send_frame(MSG_B2B_0, 8'd180, 16'd2200, 32'd345600000, payload, 1'b0, 0);
   endtask

   // each verdict but the length error, and the crc > time > type priority order
   task automatic test_verdict_priority();
      for (int i = 0; i < 4; i++) begin
         send_frame(b2b_types[i], 8'd180, 16'd2300, 32'd1000 * i, random_payload(i), 1'b0, 0);
      end
      send_frame(16'h0000, 8'd0, 16'd1, 32'h0, random_payload(0), 1'b0, 0);
      send_frame(16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, random_payload(2), 1'b0, 0);
      send_frame(MSG_B2B_1, TIME_STATUS_INVALID, 16'd2300, 32'd5, random_payload(1), 1'b0, 0);
      send_frame(MSG_B2B_2, 8'd180, 16'h0000, 32'd5, random_payload(1), 1'b0, 0);
      send_frame(MSG_B2B_3, TIME_STATUS_INVALID, 16'h0000, 32'd7, random_payload(2), 1'b1, 0);
   endtask

   // smallest and largest oversize lengths, then recovery on a clean frame
   task automatic test_length_error();
      send_oversize_header(16'hFFFF, 16'(MAX_PAYLOAD + 1));
      send_oversize_header(16'h1234, 16'hFFFF);
      send_frame(MSG_B2B_0, 8'd100, 16'd2301, 32'd42, random_payload(3), 1'b0, 0);
   endtask

   // mostly good frames with random fields; noise, cut frames and
   // oversize headers mixed in; idling switched off for some stretches
   task automatic test_random_frames();
      int stop_at;
      stop_at = frame_bytes_sent + RANDOM_BYTES;
      while (frame_bytes_sent < stop_at) begin
         idling_on = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 19))
            16, 17: begin
               repeat ($urandom_range(1, 6)) begin
                  case ($urandom_range(0, 3))
                     0:       send_byte(SYNC_A);
                     1:       send_byte(SYNC_B);
                     2:       send_byte(SYNC_C);
                     default: send_byte(8'($urandom));
                  endcase
               end
            end
            18: send_oversize_header(16'($urandom), 16'($urandom_range(MAX_PAYLOAD + 1, 65535)));
            19: send_random_frame($urandom_range(1, 40));
            default: send_random_frame(0);
         endcase
      end
      idling_on = 1'b1;
   endtask

   // receiver holds off while frames keep coming: output and skid fill up
   // and req ready has to drop
   task automatic test_receiver_hold_off();
      hold_off_request = 1'b1;
      send_frame(MSG_B2B_3, 8'd180, 16'd2310, 32'd123456, random_payload(80), 1'b0, 0);
      send_random_frame(0);
   endtask

   // sender goes quiet until every predicted item has come out
   task automatic test_sender_pause();
      send_random_frame(0);
      send_random_frame(0);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      send_random_frame(0);
   endtask

   // closing stretch at full rate on both sides
   task automatic test_unbroken_stream();
      int stop_at;
      idling_on = 1'b0;
      stop_at   = frame_bytes_sent + STREAM_BYTES;
      while (frame_bytes_sent < stop_at) send_random_frame(0);
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin : main_sequence
      int drain_cycles;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sync_hunt();
      test_verdict_priority();
      test_length_error();
      test_random_frames();
      test_receiver_hold_off();
      test_sender_pause();
      test_unbroken_stream();

      // drain: results pass the output register, and the skid stage when stalled
      req_chan.valid <= 1'b0;
      drain_cycles = 0;
      while (expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (expected_results.size() != 0) begin
         $error("%0d predicted items never arrived", expected_results.size());
         error_count++;
      end
      repeat (16) @(posedge clock);

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog for a hung handshake
   initial begin : watchdog
      #25_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
